[rtl/core/iaid_pkg.sv]
// Shared codes, field widths and controller/datapath interface types.
`timescale 1ns / 1ps

package iaid_pkg;

   localparam int OP_W      = 2;
   localparam int POS_W     = 4;
   localparam int VAL_W     = 32;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 4;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

   // Read address source for the entry RAM.
   typedef enum logic [1:0] {
      RD_BELOW,
      RD_ABOVE,
      RD_POS
   } rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              capture;
      logic              idx_load_ins;
      logic              idx_load_del;
      logic              idx_dec;
      logic              idx_inc;
      logic              rd_en;
      rd_sel_type        rd_sel;
      logic              wr_en;
      logic              wr_value;
      logic              cnt_inc;
      logic              cnt_dec;
      logic              rsp_load;
      logic              rsp_use_rd;
      logic [STAT_W-1:0] rsp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            pos_le_cnt;
      logic            pos_lt_cnt;
      logic            full;
      logic            ins_more;
      logic            del_more;
      logic            rsp_free;
   } sts_type;

endpackage

[rtl/core/iaid_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module iaid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/iaid_datapath.sv]
// Datapath: request registers, entry RAM, count, shift index and result register.
`timescale 1ns / 1ps

module iaid_datapath #(
   parameter int CAPACITY = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [iaid_pkg::OP_W-1:0]          req_operation,
   input  logic [iaid_pkg::POS_W-1:0]         req_position,
   input  logic signed [iaid_pkg::VAL_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [iaid_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [iaid_pkg::VAL_W-1:0]  rsp_read_value,
   output logic [iaid_pkg::CNT_OUT_W-1:0]     rsp_entry_count,
   input  iaid_pkg::cmd_type                  cmd,
   output iaid_pkg::sts_type                  sts
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > iaid_pkg::POS_W) ? CW : iaid_pkg::POS_W;

   logic [iaid_pkg::OP_W-1:0]      op_ff;
   logic [iaid_pkg::POS_W-1:0]     pos_ff;
   logic [iaid_pkg::VAL_W-1:0]     val_ff;
   logic [CW-1:0]                  count_ff, count_in;
   logic [CW-1:0]                  idx_ff, idx_in;
   logic                           rsp_valid_ff;
   logic [iaid_pkg::STAT_W-1:0]    rsp_status_ff;
   logic [iaid_pkg::VAL_W-1:0]     rsp_read_value_ff;
   logic [iaid_pkg::CNT_OUT_W-1:0] rsp_entry_count_ff;

   logic [CMPW-1:0]                pos_ext, cnt_ext, idx_ext;
   logic [CW-1:0]                  idx_below, idx_above;
   logic                           ram_wr_en;
   logic [AW-1:0]                  ram_wr_addr, ram_rd_addr;
   logic [iaid_pkg::VAL_W-1:0]     ram_wr_data, ram_rd_data;

   assign pos_ext   = CMPW'(pos_ff);
   assign cnt_ext   = CMPW'(count_ff);
   assign idx_ext   = CMPW'(idx_ff);
   assign idx_below = idx_ff - CW'(1);
   assign idx_above = idx_ff + CW'(1);

   assign sts.op         = op_ff;
   assign sts.pos_le_cnt = (pos_ext <= cnt_ext);
   assign sts.pos_lt_cnt = (pos_ext < cnt_ext);
   assign sts.full       = (count_ff == CW'(CAPACITY));
   assign sts.ins_more   = (idx_ext > pos_ext);
   assign sts.del_more   = ((idx_ext + CMPW'(1)) < cnt_ext);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (cmd.rd_sel)
         iaid_pkg::RD_BELOW: ram_rd_addr = idx_below[AW-1:0];
         iaid_pkg::RD_ABOVE: ram_rd_addr = idx_above[AW-1:0];
         iaid_pkg::RD_POS:   ram_rd_addr = pos_ext[AW-1:0];
         default:            ram_rd_addr = pos_ext[AW-1:0];
      endcase
   end

   // A moved entry lands at the shift index; the new word lands at the position.
   assign ram_wr_en   = cmd.wr_en;
   assign ram_wr_addr = cmd.wr_value ? pos_ext[AW-1:0] : idx_ff[AW-1:0];
   assign ram_wr_data = cmd.wr_value ? val_ff : ram_rd_data;

   iaid_ram #(
      .WIDTH(iaid_pkg::VAL_W),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (cmd.rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_load_ins) begin
         idx_in = count_ff;
      end else if (cmd.idx_load_del) begin
         idx_in = CW'(pos_ext);
      end else if (cmd.idx_dec) begin
         idx_in = idx_below;
      end else if (cmd.idx_inc) begin
         idx_in = idx_above;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.capture) begin
         op_ff  <= req_operation;
         pos_ff <= req_position;
         val_ff <= req_value;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff      <= cmd.rsp_status;
         rsp_read_value_ff  <= cmd.rsp_use_rd ? ram_rd_data : '0;
         rsp_entry_count_ff <= iaid_pkg::CNT_OUT_W'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

[rtl/core/iaid_ctrl.sv]
// Controller: sequences decode, entry shifting and result hand-off.
`timescale 1ns / 1ps

module iaid_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  iaid_pkg::sts_type sts,
   output iaid_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE,
      DECODE,
      INS_CHECK,
      INS_WR,
      DEL_CHECK,
      DEL_WR,
      READ_WAIT,
      FINISH
   } state_type;

   state_type                   state_ff, state_in;
   logic [iaid_pkg::STAT_W-1:0] status_ff, status_in;
   logic                        use_rd_ff, use_rd_in;

   assign req_ready = (state_ff == IDLE);

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = iaid_pkg::RD_POS;
      state_in   = state_ff;
      status_in  = status_ff;
      use_rd_in  = use_rd_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = DECODE;
            end
         end
         DECODE: begin
            use_rd_in = 1'b0;
            status_in = iaid_pkg::ST_BAD_POS;
            state_in  = FINISH;
            case (sts.op)
               iaid_pkg::OP_INSERT: begin
                  if (!sts.pos_le_cnt) begin
                     status_in = iaid_pkg::ST_BAD_POS;
                  end else if (sts.full) begin
                     status_in = iaid_pkg::ST_FULL;
                  end else begin
                     cmd.idx_load_ins = 1'b1;
                     state_in         = INS_CHECK;
                  end
               end
               iaid_pkg::OP_DELETE: begin
                  if (sts.pos_lt_cnt) begin
                     cmd.idx_load_del = 1'b1;
                     state_in         = DEL_CHECK;
                  end
               end
               iaid_pkg::OP_READ: begin
                  if (sts.pos_lt_cnt) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = iaid_pkg::RD_POS;
                     state_in   = READ_WAIT;
                  end
               end
               default: begin
                  state_in = FINISH;
               end
            endcase
         end
         INS_CHECK: begin
            if (sts.ins_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = iaid_pkg::RD_BELOW;
               state_in   = INS_WR;
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.wr_value = 1'b1;
               cmd.cnt_inc  = 1'b1;
               status_in    = iaid_pkg::ST_DONE;
               state_in     = FINISH;
            end
         end
         INS_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_dec = 1'b1;
            state_in    = INS_CHECK;
         end
         DEL_CHECK: begin
            if (sts.del_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = iaid_pkg::RD_ABOVE;
               state_in   = DEL_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               status_in   = iaid_pkg::ST_DONE;
               state_in    = FINISH;
            end
         end
         DEL_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = DEL_CHECK;
         end
         READ_WAIT: begin
            // The RAM holds its read data until the next read, so the
            // result may wait in FINISH for the output register.
            use_rd_in = 1'b1;
            status_in = iaid_pkg::ST_DONE;
            state_in  = FINISH;
         end
         FINISH: begin
            cmd.rsp_status = status_ff;
            cmd.rsp_use_rd = use_rd_ff;
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         status_ff <= iaid_pkg::ST_DONE;
         use_rd_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         use_rd_ff <= use_rd_in;
      end
   end

endmodule

[rtl/core/indexed_array_insert_delete.sv]
// Top level: packed array of signed words with positional insert, delete and read.
//
//   channel  direction  fields                                  transfer when
//   req      in         operation, position, value              req_valid && req_ready
//   rsp      out        status, read_value, entry_count         rsp_valid && rsp_ready
//
// Each entry moved by a shift costs one RAM read and one RAM write; insert moves
// the entries from the position upward, and delete moves those above the position.
// Reset clears the count and the result valid flag; entry contents stay undefined.
// A stalled result waits in the output register while the next request is taken;
// that request finishes once the register has been emptied.
`timescale 1ns / 1ps

module indexed_array_insert_delete #(
   parameter int CAPACITY = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [iaid_pkg::OP_W-1:0]          req_operation,
   input  logic [iaid_pkg::POS_W-1:0]         req_position,
   input  logic signed [iaid_pkg::VAL_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [iaid_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [iaid_pkg::VAL_W-1:0]  rsp_read_value,
   output logic [iaid_pkg::CNT_OUT_W-1:0]     rsp_entry_count
);

   iaid_pkg::cmd_type cmd;
   iaid_pkg::sts_type sts;

   iaid_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   iaid_datapath #(
      .CAPACITY(CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_operation  (req_operation),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_entry_count(rsp_entry_count),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule
